[src/phc_pkg.sv]
// Shared types, constants and the control program of the PID heater controller.
// Used by phc_divider and pid_heater_controller_core; depends on nothing.
package phc_pkg;

   // Datapath widths.
   localparam int unsigned ERR_W   = 17;  // target - measured, Q.4
   localparam int unsigned SUM_W   = 18;  // sum or difference of two errors
   localparam int unsigned DT_W    = 23;  // whole seconds from a 32-bit tick gap
   localparam int unsigned INTEG_W = 32;
   localparam int unsigned GAIN_W  = 24;
   localparam int unsigned LIM_W   = 31;
   localparam int unsigned MUL_A_W = 33;
   localparam int unsigned MUL_B_W = 25;
   localparam int unsigned ACC_W   = MUL_A_W + MUL_B_W;
   localparam int unsigned DIVD_W  = 42;  // dividend (quotient) width of the divider
   localparam int unsigned DIVS_W  = DT_W;
   localparam int unsigned STEP_W  = 4;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned CSR_W   = 31;
   localparam int unsigned ON_W    = 10;
   localparam int unsigned FRAC_W  = 12;  // fraction bits of the drive sum

   // Whole seconds of a 32-bit tick gap: floor(gap / 1000) equals
   // (gap * TICK_RECIP) >> TICK_SHIFT for every gap value.
   localparam int unsigned RECIP_W     = 29;
   localparam int unsigned TICK_PROD_W = 32 + RECIP_W;
   localparam int unsigned TICK_SHIFT  = 38;
   localparam logic [RECIP_W-1:0] TICK_RECIP = 29'd274877907;

   localparam logic [ACC_W-1:0]  DRIVE_MAX_Q12 = ACC_W'(1000) << FRAC_W;
   localparam logic [ON_W-1:0]   ON_TIME_MAX   = ON_W'(1000);

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_KP     = 3'd0;
   localparam logic [IDX_W-1:0] REG_KI     = 3'd1;
   localparam logic [IDX_W-1:0] REG_KD     = 3'd2;
   localparam logic [IDX_W-1:0] REG_TARGET = 3'd3;
   localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

   // Codes of drive_clamped.
   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_LOW  = 2'd1;
   localparam logic [1:0] CLAMP_HIGH = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_TICK_SCALE,
      OP_INTEG,
      OP_CLAMP,
      OP_ACC_LOAD,
      OP_ACC_ADD,
      OP_DIV_DERIV,
      OP_ACC_QUOT,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      MSEL_TRAP,
      MSEL_KP,
      MSEL_KI,
      MSEL_KD
   } msel_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_NO_DERIV,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type              op;
      logic                mul_en;
      msel_type            msel;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   // The control program. A step whose condition holds jumps to its target,
   // otherwise the next step follows.
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{op: OP_NOP, mul_en: 1'b0, msel: MSEL_TRAP, cond: COND_NEVER, target: '0};
      unique case (step)
         4'd0: begin
            w.op = OP_CAPTURE;  w.cond = COND_NO_REQ;  w.target = 4'd0;
         end
         4'd1: w.op = OP_TICK_SCALE;
         4'd2: begin
            w.mul_en = 1'b1;  w.msel = MSEL_TRAP;
         end
         4'd3: w.op = OP_INTEG;
         4'd4: w.op = OP_CLAMP;
         4'd5: begin
            w.mul_en = 1'b1;  w.msel = MSEL_KP;
         end
         4'd6: begin
            w.op = OP_ACC_LOAD;  w.mul_en = 1'b1;  w.msel = MSEL_KI;
         end
         4'd7: begin
            w.op = OP_ACC_ADD;  w.cond = COND_NO_DERIV;  w.target = 4'd12;
         end
         4'd8: begin
            w.mul_en = 1'b1;  w.msel = MSEL_KD;
         end
         4'd9: w.op = OP_DIV_DERIV;
         4'd10: begin
            w.cond = COND_DIV_BUSY;  w.target = 4'd10;
         end
         4'd11: w.op = OP_ACC_QUOT;
         4'd12: begin
            w.op = OP_FINISH;  w.cond = COND_OUT_FULL;  w.target = 4'd12;
         end
         4'd13: begin
            w.cond = COND_ALWAYS;  w.target = 4'd0;
         end
         default: w.op = OP_NOP;
      endcase
      return w;
   endfunction

endpackage

[src/pid_heater_controller_core.sv]
// Top level of the PID heater controller: microcode sequencer, datapath and ports.
// Depends on phc_pkg (program, types, constants) and phc_divider.
//
// Usage: one beat on the req_ channel carries a temperature sample, its valid
// flag (req_tuser) and the millisecond tick. The block answers each beat with
// one beat on the rsp_ channel: the heater on-time and its clamp code. The user
// must write gains, setpoint and integral limit through the csr_ port only while
// the block is idle; the block does not enforce it. A write takes effect at the
// clock edge that carries it.
// Timing: a 14-step control program drives one 33x25 multiplier, a constant
// reciprocal multiply that turns the tick gap into whole seconds in one step,
// and a restoring divider that yields one derivative quotient bit per cycle.
// The derivative is skipped for the first sample, or when under one second has
// elapsed. One item is handled at a time: req_tready is high only while the
// sequencer waits at its first step, so the next beat is taken only once the
// program of the previous one has returned there.
//
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its program stalls in its finishing step until rsp_tready frees
// that register. Reset (synchronous) loads the default registers, clears the
// error history and arms the derivative skip for the first sample.
module pid_heater_controller_core (
   input  logic        clock,
   input  logic        reset,
   // Input beat.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] measured_temp, [47:16] tick_now
   input  logic [0:0]  req_tuser,   // [0] temp_valid
   // Result beat.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] on_time_ms, [15:10] zero
   output logic [1:0]  rsp_tuser,   // [1:0] drive_clamped
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   // Configuration registers.
   logic [phc_pkg::GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic signed [15:0]         target_ff;
   logic [phc_pkg::LIM_W-1:0]  limit_ff;

   // Controller state.
   logic signed [phc_pkg::ERR_W-1:0]   last_err_ff;
   logic signed [phc_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic                               skip_ff;
   logic [31:0]                        last_tick_ff;

   // Working registers.
   logic [phc_pkg::STEP_W-1:0]         step_ff, step_in;
   logic signed [phc_pkg::ERR_W-1:0]   err_ff, err_in;
   logic [31:0]                        gap_ff;
   logic [phc_pkg::DT_W-1:0]           dt_ff;
   logic signed [phc_pkg::ACC_W-1:0]   prod_ff, prod_in;
   logic signed [phc_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                               neg_ff;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [phc_pkg::ON_W-1:0]   on_time_ff, on_time_in;
   logic [1:0]                 clamp_ff, clamp_in;

   phc_pkg::uword_type uw;
   logic               accept;
   logic               out_full;
   logic               load_out;
   logic               jump;
   logic signed [phc_pkg::SUM_W-1:0]   err_sum, err_dif;
   logic signed [phc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [phc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [phc_pkg::ACC_W-1:0]   half_trap;
   logic signed [phc_pkg::ACC_W-1:0]   lim_pos;
   logic signed [phc_pkg::ACC_W-1:0]   quot_ext;
   logic [phc_pkg::ACC_W-1:0]          prod_mag;
   logic signed [16:0]                 meas_ext, target_ext;
   logic [phc_pkg::TICK_PROD_W-1:0]    tick_prod;

   logic                       div_start;
   logic                       div_busy;
   logic [phc_pkg::DIVD_W-1:0] div_dividend;
   logic [phc_pkg::DIVS_W-1:0] div_divisor;
   logic [phc_pkg::DIVD_W-1:0] div_quotient;

   assign uw         = phc_pkg::ucode(step_ff);
   assign req_tready = (step_ff == '0) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_full   = rsp_valid_ff && !rsp_tready;
   assign load_out   = (uw.op == phc_pkg::OP_FINISH) && !out_full;

   // Sequencer.
   always_comb begin
      case (uw.cond)
         phc_pkg::COND_ALWAYS:   jump = 1'b1;
         phc_pkg::COND_NO_REQ:   jump = !req_tvalid;
         phc_pkg::COND_DIV_BUSY: jump = div_busy;
         phc_pkg::COND_NO_DERIV: jump = skip_ff || (dt_ff == '0);
         phc_pkg::COND_OUT_FULL: jump = out_full;
         default:                jump = 1'b0;
      endcase
      step_in = jump ? uw.target : step_ff + phc_pkg::STEP_W'(1);
   end

   // Shared multiplier operands.
   always_comb begin
      err_sum = phc_pkg::SUM_W'(err_ff) + phc_pkg::SUM_W'(last_err_ff);
      err_dif = phc_pkg::SUM_W'(err_ff) - phc_pkg::SUM_W'(last_err_ff);
      case (uw.msel)
         phc_pkg::MSEL_TRAP: begin
            mul_a = $signed({{(phc_pkg::MUL_A_W - phc_pkg::DT_W){1'b0}}, dt_ff});
            mul_b = phc_pkg::MUL_B_W'(err_sum);
         end
         phc_pkg::MSEL_KP: begin
            mul_a = phc_pkg::MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, kp_ff});
         end
         phc_pkg::MSEL_KI: begin
            mul_a = phc_pkg::MUL_A_W'(integ_ff);
            mul_b = $signed({1'b0, ki_ff});
         end
         default: begin
            mul_a = phc_pkg::MUL_A_W'(err_dif);
            mul_b = $signed({1'b0, kd_ff});
         end
      endcase
      prod_in = uw.mul_en ? phc_pkg::ACC_W'(mul_a * mul_b) : prod_ff;
   end

   // Datapath actions of the current step.
   always_comb begin
      meas_ext   = 17'(signed'(req_tdata[15:0]));
      target_ext = 17'(target_ff);
      err_in     = err_ff;
      if (uw.op == phc_pkg::OP_CAPTURE && accept) begin
         err_in = req_tuser[0] ? (target_ext - meas_ext) : '0;
      end

      tick_prod = phc_pkg::TICK_PROD_W'(gap_ff) *
                  phc_pkg::TICK_PROD_W'(phc_pkg::TICK_RECIP);

      // The trapezoid halving truncates toward zero.
      half_trap = (prod_ff +
                   $signed(phc_pkg::ACC_W'({1'b0, prod_ff[phc_pkg::ACC_W-1]}))) >>> 1;
      lim_pos   = $signed({{(phc_pkg::ACC_W - phc_pkg::LIM_W){1'b0}}, limit_ff});
      prod_mag  = prod_ff[phc_pkg::ACC_W-1] ? 58'(-prod_ff) : 58'(prod_ff);
      quot_ext  = $signed({{(phc_pkg::ACC_W - phc_pkg::DIVD_W){1'b0}}, div_quotient});

      acc_in   = acc_ff;
      integ_in = integ_ff;
      case (uw.op)
         phc_pkg::OP_INTEG:    acc_in = phc_pkg::ACC_W'(integ_ff) + half_trap;
         phc_pkg::OP_CLAMP: begin
            if (acc_ff > lim_pos) begin
               integ_in = phc_pkg::INTEG_W'(lim_pos);
            end else if (acc_ff < -lim_pos) begin
               integ_in = phc_pkg::INTEG_W'(-lim_pos);
            end else begin
               integ_in = acc_ff[phc_pkg::INTEG_W-1:0];
            end
         end
         phc_pkg::OP_ACC_LOAD: acc_in = prod_ff;
         phc_pkg::OP_ACC_ADD:  acc_in = acc_ff + prod_ff;
         phc_pkg::OP_ACC_QUOT: acc_in = neg_ff ? acc_ff - quot_ext : acc_ff + quot_ext;
         default:              acc_in = acc_ff;
      endcase

      div_start    = (uw.op == phc_pkg::OP_DIV_DERIV);
      div_dividend = prod_mag[phc_pkg::DIVD_W-1:0];
      div_divisor  = dt_ff;
   end

   // Output stage: clamp the Q.12 drive to an on-time.
   always_comb begin
      on_time_in   = on_time_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (acc_ff[phc_pkg::ACC_W-1]) begin
            on_time_in = '0;
            clamp_in   = phc_pkg::CLAMP_LOW;
         end else if (acc_ff > $signed(phc_pkg::DRIVE_MAX_Q12)) begin
            on_time_in = phc_pkg::ON_TIME_MAX;
            clamp_in   = phc_pkg::CLAMP_HIGH;
         end else begin
            on_time_in = acc_ff[phc_pkg::FRAC_W +: phc_pkg::ON_W];
            clamp_in   = phc_pkg::CLAMP_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= 24'd204800;
         ki_ff        <= 24'd768;
         kd_ff        <= '0;
         target_ff    <= '0;
         limit_ff     <= 31'd5333;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         skip_ff      <= 1'b1;
         last_tick_ff <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         if (csr_we) begin
            case (csr_index)
               phc_pkg::REG_KP:     kp_ff     <= csr_wdata[phc_pkg::GAIN_W-1:0];
               phc_pkg::REG_KI:     ki_ff     <= csr_wdata[phc_pkg::GAIN_W-1:0];
               phc_pkg::REG_KD:     kd_ff     <= csr_wdata[phc_pkg::GAIN_W-1:0];
               phc_pkg::REG_TARGET: target_ff <= signed'(csr_wdata[15:0]);
               phc_pkg::REG_LIMIT:  limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (uw.op == phc_pkg::OP_CAPTURE && accept) begin
            last_tick_ff <= req_tdata[47:16];
         end
         if (load_out) begin
            last_err_ff <= err_ff;
            skip_ff     <= 1'b0;
         end
      end
      err_ff     <= err_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      on_time_ff <= on_time_in;
      clamp_ff   <= clamp_in;
      if (uw.op == phc_pkg::OP_CAPTURE && accept) begin
         gap_ff <= req_tdata[47:16] - last_tick_ff;
      end
      if (uw.op == phc_pkg::OP_TICK_SCALE) begin
         dt_ff <= tick_prod[phc_pkg::TICK_SHIFT +: phc_pkg::DT_W];
      end
      if (uw.op == phc_pkg::OP_DIV_DERIV) begin
         neg_ff <= prod_ff[phc_pkg::ACC_W-1];
      end
   end

   phc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, on_time_ff};
   assign rsp_tuser  = clamp_ff;

endmodule

[src/phc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on phc_pkg for its operand widths.
module phc_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [phc_pkg::DIVD_W-1:0] dividend,
   input  logic [phc_pkg::DIVS_W-1:0] divisor,
   output logic                       busy,
   output logic [phc_pkg::DIVD_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(phc_pkg::DIVD_W + 1);

   logic [phc_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [phc_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [phc_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [phc_pkg::DIVS_W:0]   rem_sh;
   logic [phc_pkg::DIVS_W:0]   rem_sub;
   logic                       fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[phc_pkg::DIVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      fits    = (rem_sh >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(phc_pkg::DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[phc_pkg::DIVS_W-1:0] : rem_sh[phc_pkg::DIVS_W-1:0];
         quo_in = {quo_ff[phc_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[bench/pid_heater_controller_core_tb.sv]
// Self-checking bench for pid_heater_controller_core: directed and random sample beats,
// with results checked against a cycle-free PID predictor kept in the bench itself.
// Depends on phc_pkg for register indexes, clamp codes and output constants.
module pid_heater_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 150;
   localparam int SETTING_SPAN = 50;
   localparam logic [2:0] FIRST_SPARE_REG = 3'd5;
   localparam longint FULL_ON_Q12 = longint'(1000) << phc_pkg::FRAC_W;

   typedef struct {
      logic [phc_pkg::ON_W-1:0] on_time;
      logic [1:0]               clamp;
   } heat_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [15:0] measured_temp, [47:16] tick_now
   logic [0:0]  req_tuser = '0;   // [0] temp_valid
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [9:0] on_time_ms, [15:10] zero
   logic [1:0]  rsp_tuser;        // [1:0] drive_clamped
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   // Bench copy of the controller's registers and history.
   longint      kp_q8, ki_q8, kd_q8, setpoint_q4, integ_bound;
   longint      hist_error, integ_acc;
   bit          first_sample;
   logic [31:0] prev_tick;

   heat_cmd_type pending_cmds[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic [31:0] tick_cursor = '0;

   pid_heater_controller_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      heat_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            note_mismatch("unexpected result beat", -1, int'(rsp_tdata));
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_tdata[phc_pkg::ON_W-1:0] !== want.on_time)
               note_mismatch("on_time_ms", int'(want.on_time),
                             int'(rsp_tdata[phc_pkg::ON_W-1:0]));
            if (rsp_tuser !== want.clamp)
               note_mismatch("drive_clamped", int'(want.clamp), int'(rsp_tuser));
         end
      end
   end

   task automatic reset_predictor();
      kp_q8 = 204800;
      ki_q8 = 768;
      kd_q8 = 0;
      setpoint_q4 = 0;
      integ_bound = 5333;
      hist_error = 0;
      integ_acc = 0;
      first_sample = 1'b1;
      prev_tick = '0;
   endtask

   // One control step: trapezoidal integral with clamp, then P + I + D drive
   // converted to an on-time in milliseconds.
   function automatic heat_cmd_type heater_step(input logic signed [15:0] meas,
                                                input logic valid,
                                                input logic [31:0] tick);
      logic [31:0]  gap;
      longint       secs, err, integ, drive;
      heat_cmd_type cmd;
      gap = tick - prev_tick;
      secs = gap / 32'd1000;
      prev_tick = tick;
      err = valid ? setpoint_q4 - longint'(meas) : 0;
      integ = integ_acc + ((err + hist_error) * secs) / 2;
      if (integ > integ_bound) integ = integ_bound;
      if (integ < -integ_bound) integ = -integ_bound;
      integ_acc = integ;
      drive = kp_q8 * err + ki_q8 * integ;
      // The derivative needs a previous sample and at least one whole second.
      if (first_sample)
         first_sample = 1'b0;
      else if (secs != 0)
         drive += (kd_q8 * (err - hist_error)) / secs;
      hist_error = err;
      if (drive < 0) begin
         cmd.on_time = '0;
         cmd.clamp = phc_pkg::CLAMP_LOW;
      end else if (drive > FULL_ON_Q12) begin
         cmd.on_time = phc_pkg::ON_TIME_MAX;
         cmd.clamp = phc_pkg::CLAMP_HIGH;
      end else begin
         cmd.on_time = phc_pkg::ON_W'(drive >>> phc_pkg::FRAC_W);
         cmd.clamp = phc_pkg::CLAMP_NONE;
      end
      return cmd;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_sample(input logic signed [15:0] meas, input logic valid,
                              input logic [31:0] tick);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {tick, meas};
      req_tuser = valid;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_cmds.push_back(heater_step(meas, valid, tick));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         phc_pkg::REG_KP:     kp_q8 = longint'(value[phc_pkg::GAIN_W-1:0]);
         phc_pkg::REG_KI:     ki_q8 = longint'(value[phc_pkg::GAIN_W-1:0]);
         phc_pkg::REG_KD:     kd_q8 = longint'(value[phc_pkg::GAIN_W-1:0]);
         phc_pkg::REG_TARGET: setpoint_q4 = longint'(signed'(value[15:0]));
         phc_pkg::REG_LIMIT:  integ_bound = longint'(value);
         default: ;
      endcase
   endtask

   // Registers change only once every result of the previous setting is back.
   task automatic apply_setting(input logic [30:0] kp, input logic [30:0] ki,
                                input logic [30:0] kd, input logic [30:0] tgt,
                                input logic [30:0] lim);
      wait_drained();
      write_reg(phc_pkg::REG_KP, kp);
      write_reg(phc_pkg::REG_KI, ki);
      write_reg(phc_pkg::REG_KD, kd);
      write_reg(phc_pkg::REG_TARGET, tgt);
      write_reg(phc_pkg::REG_LIMIT, lim);
   endtask

   function automatic logic [30:0] pick_gain();
      case ($urandom_range(9))
         0: return '0;
         1: return 31'hFF_FFFF;
         2: return 31'($urandom());
         default: return 31'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic logic [30:0] pick_limit();
      case ($urandom_range(9))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom());
         default: return 31'($urandom_range(0, 20000));
      endcase
   endfunction

   // Derivative gain is set before the first sample, so the skip after reset shows.
   task automatic test_first_sample();
      apply_setting(256, 256, 2560, 320, 5333);
      send_sample(300, 1'b1, 32'd5000);
      send_sample(310, 1'b1, 32'd7000);
      send_sample(330, 1'b1, 32'd7500);
      send_sample(0, 1'b0, 32'd10500);
      send_sample(325, 1'b1, 32'hFFFF_FC18);
      send_sample(320, 1'b1, 32'h0000_03E8);
      tick_cursor = 32'h0000_03E8;
   endtask

   // A proportional term of exactly full scale, just above it, below zero and zero.
   task automatic test_drive_bounds();
      apply_setting(256000, 0, 0, 16, 5333);
      tick_cursor += 1500;
      send_sample(0, 1'b1, tick_cursor);
      tick_cursor += 1500;
      send_sample(-1, 1'b1, tick_cursor);
      tick_cursor += 1500;
      send_sample(17, 1'b1, tick_cursor);
      tick_cursor += 1500;
      send_sample(16, 1'b1, tick_cursor);
   endtask

   task automatic test_register_extremes();
      // Write data above each register's width must be dropped.
      apply_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_7FFF,
                    31'h7FFF_FFFF);
      tick_cursor += 2000;
      send_sample(-32768, 1'b1, tick_cursor);
      tick_cursor += 32'hFFFF_FFFF;
      send_sample(-32768, 1'b1, tick_cursor);
      tick_cursor += 2000;
      send_sample(32767, 1'b1, tick_cursor);
      tick_cursor += 3000;
      send_sample(-32768, 1'b0, tick_cursor);
      wait_drained();
      for (int i = 0; i < 3; i++) write_reg(FIRST_SPARE_REG + 3'(i), 31'h7FFF_FFFF);
      tick_cursor += 1000;
      send_sample(12345, 1'b1, tick_cursor);
      apply_setting(0, 0, 0, 31'h0000_8000, 0);
      tick_cursor += 4000;
      send_sample(32767, 1'b1, tick_cursor);
      tick_cursor += 999;
      send_sample(-32768, 1'b1, tick_cursor);
   endtask

   task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
      logic [15:0] meas;
      logic        valid;
      logic [31:0] step_ms;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % SETTING_SPAN == 0) begin
            apply_setting(pick_gain(), pick_gain(), pick_gain(), 31'($urandom()),
                          pick_limit());
            if ($urandom_range(1))
               write_reg(FIRST_SPARE_REG + 3'($urandom_range(2)), 31'($urandom()));
         end
         // Mostly samples near the setpoint, so the drive often lands in range.
         if ($urandom_range(19) < 2)
            meas = 16'($urandom());
         else
            meas = 16'(setpoint_q4 + longint'($urandom_range(0, 400)) - 200);
         valid = ($urandom_range(9) != 0);
         case ($urandom_range(19))
            0, 1, 2: step_ms = $urandom_range(0, 999);
            3, 4:    step_ms = $urandom();
            default: step_ms = $urandom_range(1000, 4999);
         endcase
         tick_cursor += step_ms;
         send_sample(meas, valid, tick_cursor);
      end
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      recv_idle_pct = 50;
      test_first_sample();
      test_drive_bounds();
      test_register_extremes();
      test_random_traffic(200, 6, 83);
      test_random_traffic(200, 83, 6);
      test_random_traffic(200, 0, 0);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_cmds.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
